FILE: src/ctt_pkg.sv
// shared types and constants of the configuration text tokenizer
package ctt_pkg;

	// one input request: a text byte or the end marker
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_end;
	} in_item_t;

	// one result request: a piece of a token
	typedef struct packed {
		logic [2:0]  token_kind;
		logic [7:0]  value_byte;
		logic        has_byte;
		logic        token_first;
		logic        token_last;
		logic [15:0] token_line;
		logic [15:0] token_column;
	} out_item_t;

	localparam int unsigned MAX_RESULTS = 3;

	// up to three results caused by one input request
	typedef struct packed {
		logic [1:0]                  count;
		out_item_t [MAX_RESULTS-1:0] res;
	} bundle_t;

	localparam logic [2:0] KIND_EOF       = 3'd0;
	localparam logic [2:0] KIND_IDENT     = 3'd1;
	localparam logic [2:0] KIND_STRING    = 3'd2;
	localparam logic [2:0] KIND_LPAREN    = 3'd3;
	localparam logic [2:0] KIND_RPAREN    = 3'd4;
	localparam logic [2:0] KIND_COMMA     = 3'd5;
	localparam logic [2:0] KIND_SEMICOLON = 3'd6;
	localparam logic [2:0] KIND_UNKNOWN   = 3'd7;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_SEMICOLON  = 8'h3B;

	// top two bits of a utf-8 continuation byte
	localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

FILE: src/ctt_scan.sv
// scanner state and the per-byte tokenizing logic
module ctt_scan
	import ctt_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     fire,
	output bundle_t  results
);

	localparam int unsigned PW = POSITION_WIDTH;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_STRING,
		MODE_ESCAPE,
		MODE_SLASH,
		MODE_COMMENT
	} mode_t;

	typedef struct packed {
		mode_t                       mode;
		logic [PW-1:0]               line;
		logic [PW-1:0]               col;
		logic [PW-1:0]               sline;
		logic [PW-1:0]               scol;
		logic                        held_v;
		logic [7:0]                  held_b;
		logic                        any_sent;
		logic [1:0]                  n;
		out_item_t [MAX_RESULTS-1:0] res;
	} ctx_t;

	mode_t         mode_q;
	logic [PW-1:0] line_q;
	logic [PW-1:0] col_q;
	logic [PW-1:0] sline_q;
	logic [PW-1:0] scol_q;
	logic          held_v_q;
	logic [7:0]    held_b_q;
	logic          any_sent_q;
	ctx_t          ctx;

	function automatic logic [15:0] f_pos16(input logic [PW-1:0] p);
		logic [PW+15:0] ext;
		ext = {16'b0, p};
		return ext[15:0];
	endfunction

	function automatic ctx_t f_put(input ctx_t c, input logic [2:0] kind, input logic [7:0] vb,
			input logic has, input logic first, input logic last);
		ctx_t r;
		r = c;
		if (c.n != 2'd3) begin
			r.res[c.n] = '{token_kind: kind, value_byte: vb, has_byte: has, token_first: first,
				token_last: last, token_line: f_pos16(c.sline), token_column: f_pos16(c.scol)};
			r.n = c.n + 2'd1;
		end
		return r;
	endfunction

	function automatic ctx_t f_push(input ctx_t c, input logic [7:0] vb);
		ctx_t r;
		r = c;
		if (c.held_v) begin
			r = f_put(r, KIND_EOF, c.held_b, 1'b1, !c.any_sent, 1'b0);
			r.any_sent = 1'b1;
		end
		r.held_b = vb;
		r.held_v = 1'b1;
		return r;
	endfunction

	function automatic ctx_t f_close(input ctx_t c, input logic [2:0] kind);
		ctx_t r;
		r = c;
		if (c.held_v)
			r = f_put(r, kind, c.held_b, 1'b1, !c.any_sent, 1'b1);
		else
			r = f_put(r, kind, 8'h00, 1'b0, !c.any_sent, 1'b1);
		r.held_v   = 1'b0;
		r.held_b   = 8'h00;
		r.any_sent = 1'b0;
		r.mode     = MODE_IDLE;
		return r;
	endfunction

	// line and code-point column advance, saturating
	function automatic ctx_t f_consume(input ctx_t c, input logic [7:0] vb);
		ctx_t r;
		r = c;
		if (vb == CH_NEWLINE) begin
			if (c.line != '1)
				r.line = c.line + PW'(1);
			r.col = PW'(1);
		end else if (vb[7:6] != CONT_TAG) begin
			if (c.col != '1)
				r.col = c.col + PW'(1);
		end
		return r;
	endfunction

	function automatic ctx_t f_mark(input ctx_t c);
		ctx_t r;
		r = c;
		r.sline = c.line;
		r.scol  = c.col;
		return r;
	endfunction

	function automatic ctx_t f_idle(input ctx_t c, input logic [7:0] vb);
		ctx_t       r;
		logic [2:0] kind;
		r = c;
		r.mode = MODE_IDLE;
		if (vb inside {8'h20, [8'h09:8'h0D]}) begin
			r = f_consume(r, vb);
		end else if (vb == CH_SLASH) begin
			r = f_mark(r);
			r.mode = MODE_SLASH;
			r = f_consume(r, vb);
		end else if (vb inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE}) begin
			r = f_mark(r);
			r.mode = MODE_IDENT;
			r = f_consume(r, vb);
			r = f_push(r, vb);
		end else if (vb == CH_QUOTE) begin
			r = f_mark(r);
			r.mode = MODE_STRING;
			r = f_consume(r, vb);
		end else begin
			case (vb)
				CH_LPAREN:    kind = KIND_LPAREN;
				CH_RPAREN:    kind = KIND_RPAREN;
				CH_COMMA:     kind = KIND_COMMA;
				CH_SEMICOLON: kind = KIND_SEMICOLON;
				default:      kind = KIND_UNKNOWN;
			endcase
			r = f_mark(r);
			r = f_consume(r, vb);
			r = f_put(r, kind, vb, 1'b1, 1'b1, 1'b1);
		end
		return r;
	endfunction

	function automatic ctx_t f_string(input ctx_t c, input logic [7:0] vb);
		ctx_t r;
		r = c;
		if (vb == CH_QUOTE) begin
			r = f_consume(r, vb);
			r = f_close(r, KIND_STRING);
		end else if (vb == CH_NUL) begin
			r = f_close(r, KIND_UNKNOWN);
			r = f_idle(r, vb);
		end else if (vb == CH_BACKSLASH) begin
			r = f_consume(r, vb);
			r.mode = MODE_ESCAPE;
		end else begin
			r = f_consume(r, vb);
			r = f_push(r, vb);
		end
		return r;
	endfunction

	always_comb begin
		ctx = '{mode: mode_q, line: line_q, col: col_q, sline: sline_q, scol: scol_q,
			held_v: held_v_q, held_b: held_b_q, any_sent: any_sent_q, n: 2'd0, res: '0};
		if (item.is_end) begin
			case (mode_q)
				MODE_IDENT:  ctx = f_close(ctx, KIND_IDENT);
				MODE_STRING: ctx = f_close(ctx, KIND_UNKNOWN);
				MODE_ESCAPE: begin
					ctx = f_push(ctx, CH_BACKSLASH);
					ctx = f_close(ctx, KIND_UNKNOWN);
				end
				MODE_SLASH:  ctx = f_put(ctx, KIND_UNKNOWN, CH_SLASH, 1'b1, 1'b1, 1'b1);
				default:     ;
			endcase
			ctx = f_mark(ctx);
			ctx = f_put(ctx, KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1);
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (item.text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
							CH_UNDERSCORE}) begin
						ctx = f_consume(ctx, item.text_byte);
						ctx = f_push(ctx, item.text_byte);
					end else begin
						ctx = f_close(ctx, KIND_IDENT);
						ctx = f_idle(ctx, item.text_byte);
					end
				end
				MODE_STRING: ctx = f_string(ctx, item.text_byte);
				MODE_ESCAPE: begin
					if (item.text_byte == CH_QUOTE) begin
						ctx = f_consume(ctx, item.text_byte);
						ctx = f_push(ctx, CH_QUOTE);
						ctx.mode = MODE_STRING;
					end else begin
						ctx = f_push(ctx, CH_BACKSLASH);
						ctx.mode = MODE_STRING;
						ctx = f_string(ctx, item.text_byte);
					end
				end
				MODE_SLASH: begin
					if (item.text_byte == CH_SLASH) begin
						ctx = f_consume(ctx, item.text_byte);
						ctx.mode = MODE_COMMENT;
					end else begin
						ctx = f_put(ctx, KIND_UNKNOWN, CH_SLASH, 1'b1, 1'b1, 1'b1);
						ctx = f_idle(ctx, item.text_byte);
					end
				end
				MODE_COMMENT: begin
					if (item.text_byte == CH_NEWLINE) begin
						ctx.mode = MODE_IDLE;
						ctx = f_consume(ctx, item.text_byte);
					end else if (item.text_byte == CH_NUL) begin
						ctx = f_idle(ctx, item.text_byte);
					end else begin
						ctx = f_consume(ctx, item.text_byte);
					end
				end
				default: ctx = f_idle(ctx, item.text_byte);
			endcase
		end
		results.count = ctx.n;
		results.res   = ctx.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			line_q     <= PW'(1);
			col_q      <= PW'(1);
			sline_q    <= PW'(1);
			scol_q     <= PW'(1);
			held_v_q   <= 1'b0;
			held_b_q   <= 8'h00;
			any_sent_q <= 1'b0;
		end else if (fire) begin
			if (item.is_end) begin
				// end of text: back to the reset state
				mode_q     <= MODE_IDLE;
				line_q     <= PW'(1);
				col_q      <= PW'(1);
				sline_q    <= PW'(1);
				scol_q     <= PW'(1);
				held_v_q   <= 1'b0;
				held_b_q   <= 8'h00;
				any_sent_q <= 1'b0;
			end else begin
				mode_q     <= ctx.mode;
				line_q     <= ctx.line;
				col_q      <= ctx.col;
				sline_q    <= ctx.sline;
				scol_q     <= ctx.scol;
				held_v_q   <= ctx.held_v;
				held_b_q   <= ctx.held_b;
				any_sent_q <= ctx.any_sent;
			end
		end
	end

endmodule

FILE: src/config_text_tokenizer.sv
// top level of the configuration text tokenizer
//
// usage:
//   text channel (text_valid/text_ready/text) takes one request per cycle while
//   text_ready is high: a raw byte, or the end marker (is_end set). token channel
//   (token_valid/token_ready/token) returns token pieces, at most one value byte
//   each; the last piece of a token carries the kind and token_last, the first
//   carries token_first. every piece carries the line and code-point column where
//   its token starts. a request is held in the input register, its results in the
//   result register. throughput: one text request per cycle while each request
//   yields at most one result and token_ready stays high. a request that yields k
//   results occupies the result register until all k are taken, since the token
//   port moves one result per cycle; at most three results come from one request.
//   reset: scanner idle, line and column at 1, no held value byte, both
//   registers empty. the end marker closes any open token, emits eof and
//   returns the scanner to that same state.
//   stall: while the receiver holds token_ready low the result register holds;
//   the input register keeps taking one more request, after which text_ready
//   drops until results drain.
module config_text_tokenizer
	import ctt_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      text_valid,
	output logic      text_ready,
	input  in_item_t  text,
	output logic      token_valid,
	input  logic      token_ready,
	output out_item_t token
);

	// input register
	logic     valid_s1;
	in_item_t item_s1;

	// result register: results of one request, drained one per cycle while token_ready is high
	bundle_t  bundle_s2;
	logic [1:0] idx_q;

	bundle_t scan_res;
	logic    step_fire;
	logic    token_fire;
	logic    last_taken;
	logic    bundle_free;

	assign token_valid = (idx_q != bundle_s2.count);
	assign token       = bundle_s2.res[idx_q];
	assign token_fire  = token_valid && token_ready;
	assign last_taken  = token_fire && ((idx_q + 2'd1) == bundle_s2.count);

	// the scanner may run when the result register is empty or empties now
	assign bundle_free = !token_valid || last_taken;
	assign step_fire   = valid_s1 && bundle_free;
	assign text_ready  = !valid_s1 || step_fire;

	ctt_scan #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (step_fire),
		.results(scan_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && text_ready) begin
			valid_s1 <= 1'b1;
		end else if (step_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			item_s1 <= text;
		end
	end

	// result register and drain pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bundle_s2 <= '0;
			idx_q     <= 2'd0;
		end else if (step_fire) begin
			bundle_s2 <= scan_res;
			idx_q     <= 2'd0;
		end else if (last_taken) begin
			bundle_s2.count <= 2'd0;
			idx_q           <= 2'd0;
		end else if (token_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// drain pointer never passes the number of stored results
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q <= bundle_s2.count) && (bundle_s2.count != 2'd3 || idx_q != 2'd3))
		else $error("result drain pointer out of range");

	// the scanner never overwrites results that are still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |-> (!token_valid || last_taken))
		else $error("result register overwritten before drained");

	// only the closing piece of a token carries a kind
	a_kind_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !token.token_last) |-> (token.token_kind == KIND_EOF))
		else $error("token kind on a non-final piece");

	// a waiting input request is held until the scanner takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step_fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a request");

endmodule
